// ===== rtl/ac3fs_pkg.sv =====
// Package for the AC-3 frame sync deframer: beat payload types, syncword
// constants and the rate and frame-size code tables. No dependencies.
package ac3fs_pkg;

  localparam int unsigned WinLen    = 5;
  localparam int unsigned HeldLen   = WinLen - 1;
  localparam int unsigned FillW     = $clog2(WinLen);
  localparam int unsigned IdxW      = $clog2(HeldLen);
  localparam int unsigned SizeCodes = 38;

  localparam logic [7:0]  SYNC_HI   = 8'h0B;
  localparam logic [7:0]  SYNC_LO   = 8'h77;
  localparam logic [7:0]  SIZE_MASK = 8'h3F;

  localparam logic [1:0]  RC_48K  = 2'd0;
  localparam logic [1:0]  RC_44K1 = 2'd1;
  localparam logic [1:0]  RC_32K  = 2'd2;
  localparam logic [1:0]  RC_NONE = 2'd3;

  localparam logic [15:0] RATE_48K  = 16'd48000;
  localparam logic [15:0] RATE_44K1 = 16'd44100;
  localparam logic [15:0] RATE_32K  = 16'd32000;

  typedef struct packed {
    logic [7:0] in_byte;
  } in_beat_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        first_byte;
    logic        last_byte;
    logic [15:0] sample_rate;
    logic [11:0] frame_length;
  } out_beat_t;

  typedef struct packed {
    logic        ok;
    logic [15:0] rate;
    logic [11:0] length;
  } hdr_info_t;

  function automatic logic [15:0] rate_of(logic [1:0] rc);
    logic [15:0] r;
    case (rc)
      RC_48K:  r = RATE_48K;
      RC_44K1: r = RATE_44K1;
      RC_32K:  r = RATE_32K;
      default: r = RATE_48K;
    endcase
    return r;
  endfunction

  // words per frame for 48 / 44.1 / 32 kHz, packed {w48, w44, w32}
  function automatic logic [32:0] words_of(logic [5:0] sc);
    logic [32:0] t;
    case (sc)
      6'd0:    t = {11'd64,   11'd69,   11'd96};
      6'd1:    t = {11'd64,   11'd70,   11'd96};
      6'd2:    t = {11'd80,   11'd87,   11'd120};
      6'd3:    t = {11'd80,   11'd88,   11'd120};
      6'd4:    t = {11'd96,   11'd104,  11'd144};
      6'd5:    t = {11'd96,   11'd105,  11'd144};
      6'd6:    t = {11'd112,  11'd121,  11'd168};
      6'd7:    t = {11'd112,  11'd122,  11'd168};
      6'd8:    t = {11'd128,  11'd139,  11'd192};
      6'd9:    t = {11'd128,  11'd140,  11'd192};
      6'd10:   t = {11'd160,  11'd174,  11'd240};
      6'd11:   t = {11'd160,  11'd175,  11'd240};
      6'd12:   t = {11'd192,  11'd208,  11'd288};
      6'd13:   t = {11'd192,  11'd209,  11'd288};
      6'd14:   t = {11'd224,  11'd243,  11'd336};
      6'd15:   t = {11'd224,  11'd244,  11'd336};
      6'd16:   t = {11'd256,  11'd278,  11'd384};
      6'd17:   t = {11'd256,  11'd279,  11'd384};
      6'd18:   t = {11'd320,  11'd348,  11'd480};
      6'd19:   t = {11'd320,  11'd349,  11'd480};
      6'd20:   t = {11'd384,  11'd417,  11'd576};
      6'd21:   t = {11'd384,  11'd418,  11'd576};
      6'd22:   t = {11'd448,  11'd487,  11'd672};
      6'd23:   t = {11'd448,  11'd488,  11'd672};
      6'd24:   t = {11'd512,  11'd557,  11'd768};
      6'd25:   t = {11'd512,  11'd558,  11'd768};
      6'd26:   t = {11'd640,  11'd696,  11'd960};
      6'd27:   t = {11'd640,  11'd697,  11'd960};
      6'd28:   t = {11'd768,  11'd835,  11'd1152};
      6'd29:   t = {11'd768,  11'd836,  11'd1152};
      6'd30:   t = {11'd896,  11'd975,  11'd1344};
      6'd31:   t = {11'd896,  11'd976,  11'd1344};
      6'd32:   t = {11'd1024, 11'd1114, 11'd1536};
      6'd33:   t = {11'd1024, 11'd1115, 11'd1536};
      6'd34:   t = {11'd1152, 11'd1253, 11'd1728};
      6'd35:   t = {11'd1152, 11'd1254, 11'd1728};
      6'd36:   t = {11'd1280, 11'd1393, 11'd1920};
      6'd37:   t = {11'd1280, 11'd1394, 11'd1920};
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage

// ===== rtl/ac3fs_if.sv =====
// Valid/ready channel interfaces for the deframer's byte input and frame output.
// Depends on ac3fs_pkg for the beat payload types.
interface ac3fs_in_if;
  import ac3fs_pkg::*;
  logic     valid;
  logic     ready;
  in_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ac3fs_out_if;
  import ac3fs_pkg::*;
  logic      valid;
  logic      ready;
  out_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/ac3_frame_sync_deframer_core.sv =====
// AC-3 frame sync deframer: hunts for sync headers in a byte stream and
// forwards whole frames with first/last marks, sample rate and length.
// A frame byte is pushed into the output stage when the byte four places behind
// it is accepted. Throughput: one byte per cycle while the output stage has space, set by the window update.
// Reset: window empty, hunting, rate 48000, length zero, output stage empty.
// Depends on ac3fs_pkg, ac3fs_if, ac3fs_hdr_dec, ac3fs_out_buf.
module ac3_frame_sync_deframer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  ac3fs_in_if.sink    in_i,
  ac3fs_out_if.source out_o
);
  import ac3fs_pkg::*;

  logic [7:0]       win_q [HeldLen];
  logic [7:0]       win_d [HeldLen];
  logic [FillW-1:0] fill_q, fill_d;
  logic [11:0]      left_q, left_d;
  logic [15:0]      rate_q, rate_d;
  logic [11:0]      len_q, len_d;

  logic       accept;
  logic       full;
  logic [7:0] new_byte;
  logic       space;
  logic       push;
  out_beat_t  push_data;
  hdr_info_t  hdr;

  assign new_byte  = in_i.data.in_byte;
  assign accept    = in_i.valid && space;
  assign in_i.ready = space;
  assign full      = (fill_q == FillW'(HeldLen));

  ac3fs_hdr_dec u_hdr_dec (
    .sync0_i (win_q[0]),
    .sync1_i (win_q[1]),
    .code_i  (new_byte),
    .info_o  (hdr)
  );

  always_comb begin
    win_d     = win_q;
    fill_d    = fill_q;
    left_d    = left_q;
    rate_d    = rate_q;
    len_d     = len_q;
    push      = 1'b0;
    push_data = '{out_byte: win_q[0], first_byte: 1'b0, last_byte: 1'b0,
                  sample_rate: rate_q, frame_length: len_q};
    if (accept) begin
      if (!full) begin
        win_d[fill_q[IdxW-1:0]] = new_byte;
        fill_d = fill_q + FillW'(1);
      end else begin
        for (int i = 0; i < HeldLen - 1; i++) begin
          win_d[i] = win_q[i+1];
        end
        win_d[HeldLen-1] = new_byte;
        if (left_q != '0) begin
          push                = 1'b1;
          push_data.last_byte = (left_q == 12'd1);
          left_d              = left_q - 12'd1;
        end else if (hdr.ok) begin
          push                   = 1'b1;
          push_data.first_byte   = 1'b1;
          push_data.sample_rate  = hdr.rate;
          push_data.frame_length = hdr.length;
          rate_d                 = hdr.rate;
          len_d                  = hdr.length;
          left_d                 = hdr.length - 12'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      left_q <= '0;
      rate_q <= RATE_48K;
      len_q  <= '0;
    end else begin
      fill_q <= fill_d;
      left_q <= left_d;
      rate_q <= rate_d;
      len_q  <= len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

  ac3fs_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .space_o     (space),
    .out_o       (out_o)
  );

endmodule

// ===== rtl/ac3fs_hdr_dec.sv =====
// Header check for one full window: syncword match, rate and size code range,
// sample rate and frame length lookup. Depends on ac3fs_pkg.
module ac3fs_hdr_dec (
  input  logic [7:0]             sync0_i,
  input  logic [7:0]             sync1_i,
  input  logic [7:0]             code_i,
  output ac3fs_pkg::hdr_info_t   info_o
);
  import ac3fs_pkg::*;

  logic [1:0]  rc;
  logic [5:0]  sc;
  logic [32:0] words;
  logic [10:0] word_cnt;

  assign rc    = code_i[7:6];
  assign sc    = 6'(code_i & SIZE_MASK);
  assign words = words_of(sc);

  always_comb begin
    case (rc)
      RC_48K:  word_cnt = words[32:22];
      RC_44K1: word_cnt = words[21:11];
      RC_32K:  word_cnt = words[10:0];
      default: word_cnt = '0;
    endcase
  end

  assign info_o.ok     = (sync0_i == SYNC_HI) && (sync1_i == SYNC_LO) &&
                         (rc != RC_NONE) && (32'(sc) < SizeCodes);
  assign info_o.rate   = rate_of(rc);
  assign info_o.length = {word_cnt, 1'b0};

endmodule

// ===== rtl/ac3fs_out_buf.sv =====
// Two-entry output stage: result register plus skid register, so a beat is
// taken while the result register waits. Depends on ac3fs_pkg, ac3fs_if.
module ac3fs_out_buf (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  ac3fs_pkg::out_beat_t  push_data_i,
  output logic                  space_o,
  ac3fs_out_if.source           out_o
);
  import ac3fs_pkg::*;

  logic      main_vld_q, main_vld_d;
  logic      skid_vld_q, skid_vld_d;
  out_beat_t main_q, main_d;
  out_beat_t skid_q, skid_d;
  logic      pop;

  assign pop     = main_vld_q && out_o.ready;
  assign space_o = !skid_vld_q;

  always_comb begin
    main_vld_d = main_vld_q;
    skid_vld_d = skid_vld_q;
    main_d     = main_q;
    skid_d     = skid_q;
    if (pop) begin
      main_vld_d = 1'b0;
    end
    if (skid_vld_q && (pop || !main_vld_q)) begin
      main_d     = skid_q;
      main_vld_d = 1'b1;
      skid_vld_d = 1'b0;
    end else if (push_i) begin
      if (!main_vld_q || pop) begin
        main_d     = push_data_i;
        main_vld_d = 1'b1;
      end else begin
        skid_d     = push_data_i;
        skid_vld_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_vld_q <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      main_vld_q <= main_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  assign out_o.valid = main_vld_q;
  assign out_o.data  = main_q;

endmodule
